@@ sv/ep0_pkg.sv @@
`default_nettype none

package ep0_pkg;

  localparam int MAX_PACKET      = 8;
  localparam int NUM_DESCRIPTORS = 6;
  localparam int DIR_SIZE        = 6;
  localparam int DIR_SEARCH      = (NUM_DESCRIPTORS < DIR_SIZE) ? NUM_DESCRIPTORS : DIR_SIZE;
  localparam int LEN_W           = 7;
  localparam int FIFO_DEPTH      = 4;

  typedef enum logic [2:0] {
    OP_BUS_RESET = 3'd0,
    OP_SETUP     = 3'd1,
    OP_IN        = 3'd2,
    OP_OUT       = 3'd3,
    OP_SOF       = 3'd4
  } op_t;

  localparam logic [15:0] REQ_SET_ADDRESS  = 16'h0500;
  localparam logic [15:0] REQ_SET_CONFIG   = 16'h0900;
  localparam logic [15:0] REQ_GET_DESC_DEV = 16'h0680;
  localparam logic [15:0] REQ_GET_DESC_IF  = 16'h0681;

  localparam logic [15:0] LANG_NONE  = 16'h0000;
  localparam logic [15:0] LANG_EN_US = 16'h0409;

  localparam logic [15:0] DIR_VALUE [DIR_SIZE] = '{
    16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302, 16'h2200
  };
  localparam logic [15:0] DIR_INDEX [DIR_SIZE] = '{
    LANG_NONE, LANG_NONE, LANG_NONE, LANG_EN_US, LANG_EN_US, LANG_NONE
  };
  localparam logic [LEN_W-1:0] DIR_LEN [DIR_SIZE] = '{
    7'd18, 7'd34, 7'd4, 7'd26, 7'd36, 7'd52
  };

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] request_word;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
  } item_t;

  typedef struct packed {
    logic       arm_tx;
    logic       tx_bank;
    logic       tx_data1;
    logic [3:0] tx_count;
    logic [2:0] tx_descriptor;
    logic [5:0] tx_offset;
    logic       stall_res;
    logic       address_write;
    logic [6:0] new_address;
    logic       rx_rearm;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] beats;
    result_t    beat0;
    result_t    beat1;
  } push_t;

endpackage

`default_nettype wire

@@ sv/usb_ep0_control_responder.sv @@
`default_nettype none

// Control endpoint 0 responder. Each token event (bus reset, SETUP, IN, OUT, start of
// frame) gives zero, one or two result beats; a get-descriptor reply arms up to two
// packets and the rest goes out on later IN tokens. An item is taken every cycle as long
// as results drain: it is held in the input register, is decoded in one pass
// against the endpoint state, and its beats enter a four-beat result queue, from which
// the output sends one beat per cycle while result_stall is low. The input stalls
// while an item waits in the input register and the queue holds more than two beats.
module usb_ep0_control_responder
  import ep0_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic  in_full;
  item_t in_q;
  logic  room;
  logic  fire;
  push_t push;

  assign fire       = in_full && room;
  assign item_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_q <= item;
    end
  end

  ep0_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_q),
    .push (push)
  );

  ep0_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ sv/ep0_core.sv @@
`default_nettype none

module ep0_core
  import ep0_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire item_t item,
  output push_t      push
);

  logic             bank_odd, bank_odd_next;
  logic             data_toggle, data_toggle_next;
  logic             pending_valid, pending_valid_next;
  logic [2:0]       pending_descriptor, pending_descriptor_next;
  logic [5:0]       pending_offset, pending_offset_next;
  logic [5:0]       pending_remaining, pending_remaining_next;
  logic             address_pending, address_pending_next;
  logic [6:0]       held_address, held_address_next;

  logic             is_set_addr, is_set_cfg, is_get_desc;
  logic             found;
  logic [2:0]       hit_idx;
  logic [LEN_W-1:0] hit_len;
  logic [2:0]       desc;
  logic [LEN_W-1:0] desc_len, cut, size0, rem1, size1, rem2;
  logic             two, more;
  logic [LEN_W-1:0] in_size;
  logic [5:0]       in_rem;

  function automatic logic [LEN_W-1:0] chunk(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : len;
  endfunction

  assign is_set_addr = (item.request_word == REQ_SET_ADDRESS);
  assign is_set_cfg  = (item.request_word == REQ_SET_CONFIG);
  assign is_get_desc = (item.request_word == REQ_GET_DESC_DEV) ||
                       (item.request_word == REQ_GET_DESC_IF);

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    hit_len = '0;
    for (int i = DIR_SEARCH - 1; i >= 0; i--) begin
      if (DIR_VALUE[i] == item.setup_value && DIR_INDEX[i] == item.setup_index) begin
        found   = 1'b1;
        hit_idx = 3'(i);
        hit_len = DIR_LEN[i];
      end
    end
  end

  assign desc     = is_get_desc ? hit_idx : 3'd0;
  assign desc_len = is_get_desc ? hit_len : '0;
  assign cut      = (item.setup_length < 16'(desc_len)) ? item.setup_length[LEN_W-1:0]
                                                        : desc_len;
  assign size0    = chunk(cut);
  assign rem1     = cut - size0;
  assign two      = !(rem1 == '0 && size0 < LEN_W'(MAX_PACKET));
  assign size1    = chunk(rem1);
  assign rem2     = rem1 - size1;
  assign more     = !(rem2 == '0 && size1 < LEN_W'(MAX_PACKET));

  assign in_size  = chunk({1'b0, pending_remaining});
  assign in_rem   = pending_remaining - 6'(in_size);

  always_comb begin
    bank_odd_next           = bank_odd;
    data_toggle_next        = data_toggle;
    pending_valid_next      = pending_valid;
    pending_descriptor_next = pending_descriptor;
    pending_offset_next     = pending_offset;
    pending_remaining_next  = pending_remaining;
    address_pending_next    = address_pending;
    held_address_next       = held_address;
    push                    = '0;
    if (fire) begin
      case (op_t'(item.op))
        OP_BUS_RESET: begin
          bank_odd_next                = 1'b0;
          pending_valid_next           = 1'b0;
          pending_descriptor_next      = '0;
          pending_offset_next          = '0;
          pending_remaining_next       = '0;
          address_pending_next         = 1'b0;
          held_address_next            = '0;
          push.beats                   = 2'd1;
          push.beat0.address_write     = 1'b1;
          push.beat0.rx_rearm          = 1'b1;
          push.beat0.last              = 1'b1;
        end
        OP_SETUP: begin
          pending_valid_next      = 1'b0;
          pending_descriptor_next = '0;
          pending_offset_next     = '0;
          pending_remaining_next  = '0;
          address_pending_next    = 1'b0;
          data_toggle_next        = 1'b1;
          push.beat0.rx_rearm     = 1'b1;
          if (is_set_addr || is_set_cfg || (is_get_desc && found)) begin
            push.beats               = two ? 2'd2 : 2'd1;
            push.beat0.arm_tx        = 1'b1;
            push.beat0.tx_bank       = bank_odd;
            push.beat0.tx_data1      = 1'b1;
            push.beat0.tx_count      = 4'(size0);
            push.beat0.tx_descriptor = desc;
            push.beat0.last          = !two;
            bank_odd_next            = two ? bank_odd : ~bank_odd;
            data_toggle_next         = two;
            if (two) begin
              push.beat1.arm_tx        = 1'b1;
              push.beat1.tx_bank       = ~bank_odd;
              push.beat1.tx_data1      = 1'b0;
              push.beat1.tx_count      = 4'(size1);
              push.beat1.tx_descriptor = desc;
              push.beat1.tx_offset     = 6'(size0);
              push.beat1.last          = 1'b1;
              if (more) begin
                pending_valid_next      = 1'b1;
                pending_descriptor_next = desc;
                pending_offset_next     = 6'(size0 + size1);
                pending_remaining_next  = 6'(rem2);
              end
            end
            if (is_set_addr) begin
              address_pending_next = 1'b1;
              held_address_next    = item.setup_value[6:0];
            end
          end else begin
            push.beats           = 2'd1;
            push.beat0.stall_res = 1'b1;
            push.beat0.last      = 1'b1;
          end
        end
        OP_IN: begin
          if (pending_valid || address_pending) begin
            push.beats      = 2'd1;
            push.beat0.last = 1'b1;
          end
          if (pending_valid) begin
            push.beat0.arm_tx        = 1'b1;
            push.beat0.tx_bank       = bank_odd;
            push.beat0.tx_data1      = data_toggle;
            push.beat0.tx_count      = 4'(in_size);
            push.beat0.tx_descriptor = pending_descriptor;
            push.beat0.tx_offset     = pending_offset;
            bank_odd_next            = ~bank_odd;
            data_toggle_next         = ~data_toggle;
            pending_offset_next      = pending_offset + 6'(in_size);
            pending_remaining_next   = in_rem;
            pending_valid_next       = (in_rem != '0) || (in_size == LEN_W'(MAX_PACKET));
          end
          if (address_pending) begin
            push.beat0.address_write = 1'b1;
            push.beat0.new_address   = held_address;
            address_pending_next     = 1'b0;
          end
        end
        OP_OUT: begin
          push.beats          = 2'd1;
          push.beat0.rx_rearm = 1'b1;
          push.beat0.last     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_odd           <= 1'b0;
      data_toggle        <= 1'b0;
      pending_valid      <= 1'b0;
      pending_descriptor <= '0;
      pending_offset     <= '0;
      pending_remaining  <= '0;
      address_pending    <= 1'b0;
      held_address       <= '0;
    end else begin
      bank_odd           <= bank_odd_next;
      data_toggle        <= data_toggle_next;
      pending_valid      <= pending_valid_next;
      pending_descriptor <= pending_descriptor_next;
      pending_offset     <= pending_offset_next;
      pending_remaining  <= pending_remaining_next;
      address_pending    <= address_pending_next;
      held_address       <= held_address_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/ep0_result_fifo.sv @@
`default_nettype none

module ep0_result_fifo
  import ep0_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire push_t   push,
  output logic         room,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign pop          = result_valid && !result_stall;
  assign result_valid = (count != '0);
  assign result       = mem[rd_ptr];
  assign room         = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.beats != 2'd0) begin
      mem[wr_ptr] <= push.beat0;
    end
    if (push.beats == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.beat1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.beats);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.beats) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + (CNT_W+1)'(push.beats)) <= (CNT_W+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.beats != 2'd0) |-> room)
    else $error("beat pushed without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && push.beats == 2'd0) |=> (count == $past(count) - CNT_W'(1)))
    else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

@@ test/usb_ep0_control_responder_tb.sv @@
module usb_ep0_control_responder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ep0_pkg::*;

  localparam int HANG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 330;

  class ep0_scoreboard;
    result_t expected_q[$];
    int errors;
    bit bank_odd;
    bit data_toggle;
    bit pend_valid;
    bit [2:0] pend_desc;
    bit [5:0] pend_off;
    bit [5:0] pend_rem;
    bit addr_pend;
    bit [6:0] held_addr;

    function int chunk_len(int len);
      return (len > MAX_PACKET) ? MAX_PACKET : len;
    endfunction

    function result_t arm_packet(int count, int desc, int off);
      result_t r;
      r = '0;
      r.arm_tx = 1'b1;
      r.tx_bank = bank_odd;
      r.tx_data1 = data_toggle;
      r.tx_count = count[3:0];
      r.tx_descriptor = desc[2:0];
      r.tx_offset = off[5:0];
      bank_odd = ~bank_odd;
      data_toggle = ~data_toggle;
      return r;
    endfunction

    function void clear_transfer();
      pend_valid = 0;
      pend_desc = '0;
      pend_off = '0;
      pend_rem = '0;
      addr_pend = 0;
    endfunction

    function void predict_setup(item_t it);
      result_t r0, r1;
      int len, desc, off, size;
      bit ok;
      bit found;
      clear_transfer();
      data_toggle = 1'b1;
      r0 = '0;
      r0.rx_rearm = 1'b1;
      len = 0;
      desc = 0;
      ok = 1;
      if (it.request_word == REQ_SET_ADDRESS) begin
        addr_pend = 1;
        held_addr = it.setup_value[6:0];
      end else if (it.request_word == REQ_SET_CONFIG) begin
      end else if (it.request_word == REQ_GET_DESC_DEV || it.request_word == REQ_GET_DESC_IF) begin
        found = 0;
        for (int i = 0; i < DIR_SEARCH; i++) begin
          if (!found && DIR_VALUE[i] == it.setup_value && DIR_INDEX[i] == it.setup_index) begin
            found = 1;
            desc = i;
            len = int'(DIR_LEN[i]);
          end
        end
        ok = found;
      end else begin
        ok = 0;
      end
      if (!ok) begin
        r0.stall_res = 1'b1;
        r0.last = 1'b1;
        expected_q.push_back(r0);
        return;
      end
      if (len > int'(it.setup_length)) len = int'(it.setup_length);
      size = chunk_len(len);
      r1 = arm_packet(size, desc, 0);
      r1.rx_rearm = 1'b1;
      r0 = r1;
      off = size;
      len -= size;
      if (len == 0 && size < MAX_PACKET) begin
        r0.last = 1'b1;
        expected_q.push_back(r0);
        return;
      end
      size = chunk_len(len);
      r1 = arm_packet(size, desc, off);
      r1.last = 1'b1;
      off += size;
      len -= size;
      if (!(len == 0 && size < MAX_PACKET)) begin
        pend_valid = 1;
        pend_desc = desc[2:0];
        pend_off = off[5:0];
        pend_rem = len[5:0];
      end
      expected_q.push_back(r0);
      expected_q.push_back(r1);
    endfunction

    function void predict_in();
      result_t r;
      int size;
      bit any;
      r = '0;
      any = 0;
      if (pend_valid) begin
        size = chunk_len(int'(pend_rem));
        r = arm_packet(size, int'(pend_desc), int'(pend_off));
        pend_off = pend_off + size[5:0];
        pend_rem = pend_rem - size[5:0];
        pend_valid = (pend_rem > 0 || size == MAX_PACKET);
        any = 1;
      end
      if (addr_pend) begin
        r.address_write = 1'b1;
        r.new_address = held_addr;
        addr_pend = 0;
        any = 1;
      end
      if (any) begin
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void note_item(item_t it);
      result_t r;
      r = '0;
      case (it.op)
        OP_BUS_RESET: begin
          bank_odd = 0;
          clear_transfer();
          held_addr = '0;
          r.address_write = 1'b1;
          r.rx_rearm = 1'b1;
          r.last = 1'b1;
          expected_q.push_back(r);
        end
        OP_SETUP: predict_setup(it);
        OP_IN: predict_in();
        OP_OUT: begin
          r.rx_rearm = 1'b1;
          r.last = 1'b1;
          expected_q.push_back(r);
        end
        default: begin
        end
      endcase
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        $error("%s expected %0d actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("arm_tx", e.arm_tx, got.arm_tx);
      cmp("tx_bank", e.tx_bank, got.tx_bank);
      cmp("tx_data1", e.tx_data1, got.tx_data1);
      cmp("tx_count", e.tx_count, got.tx_count);
      cmp("tx_descriptor", e.tx_descriptor, got.tx_descriptor);
      cmp("tx_offset", e.tx_offset, got.tx_offset);
      cmp("stall_res", e.stall_res, got.stall_res);
      cmp("address_write", e.address_write, got.address_write);
      cmp("new_address", e.new_address, got.new_address);
      cmp("rx_rearm", e.rx_rearm, got.rx_rearm);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  ep0_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent_count = 0;
  int hang_count = 0;

  usb_ep0_control_responder uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_result(result);
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        hang_count <= hang_count + 1;
      end
    end
  end

  function automatic item_t mk(logic [2:0] op, logic [15:0] req, logic [15:0] val,
                               logic [15:0] idx, logic [15:0] len);
    item_t it;
    it.op = op;
    it.request_word = req;
    it.setup_value = val;
    it.setup_index = idx;
    it.setup_length = len;
    return it;
  endfunction

  function automatic item_t rnd_item(logic [2:0] op);
    return mk(op, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 16'($urandom_range(65535)));
  endfunction

  task automatic send_item(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    sent_count++;
  endtask

  task automatic send_descriptor_transfer();
    int e;
    item_t it;
    e = $urandom_range(DIR_SIZE - 1);
    it = rnd_item(OP_SETUP);
    it.request_word = $urandom_range(1) ? REQ_GET_DESC_DEV : REQ_GET_DESC_IF;
    it.setup_value = DIR_VALUE[e];
    it.setup_index = DIR_INDEX[e];
    if ($urandom_range(9) == 0) it.setup_index ^= 16'h1 << $urandom_range(15);
    case ($urandom_range(3))
      0: begin
      end
      1: it.setup_length = 16'($urandom_range(64));
      2: it.setup_length = 16'(8 * $urandom_range(7));
      default: it.setup_length = 16'(DIR_LEN[e] + $urandom_range(2) - 1);
    endcase
    send_item(it);
    repeat ($urandom_range(8)) begin
      if ($urandom_range(9) == 0) send_item(rnd_item($urandom_range(1) ? OP_SOF : OP_OUT));
      send_item(rnd_item(OP_IN));
    end
  endtask

  task automatic send_sequence();
    int kind;
    item_t it;
    kind = $urandom_range(99);
    if (kind < 45) begin
      send_descriptor_transfer();
    end else if (kind < 60) begin
      it = rnd_item(OP_SETUP);
      it.request_word = REQ_SET_ADDRESS;
      send_item(it);
      repeat ($urandom_range(2)) send_item(rnd_item(OP_IN));
    end else if (kind < 68) begin
      it = rnd_item(OP_SETUP);
      it.request_word = REQ_SET_CONFIG;
      send_item(it);
      send_item(rnd_item(OP_IN));
    end else if (kind < 78) begin
      send_item(rnd_item(OP_SETUP));
    end else if (kind < 86) begin
      send_item(rnd_item(OP_IN));
    end else if (kind < 91) begin
      send_item(rnd_item(OP_OUT));
    end else if (kind < 95) begin
      send_item(rnd_item(OP_SOF));
    end else if (kind < 97) begin
      send_item(rnd_item(OP_BUS_RESET));
    end else begin
      send_item(rnd_item(3'($urandom_range(5, 7))));
    end
  endtask

  task automatic run_directed();
    send_item(mk(OP_BUS_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_SETUP, REQ_GET_DESC_DEV, DIR_VALUE[0], DIR_INDEX[0], 16'hFFFF));
    send_item(mk(OP_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_SETUP, REQ_GET_DESC_IF, DIR_VALUE[5], DIR_INDEX[5], 16'hFFFF));
    // stale pending data must be dropped by the next setup
    send_item(mk(OP_SETUP, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000));
    send_item(mk(OP_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_SETUP, REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(mk(OP_IN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(mk(OP_SETUP, REQ_GET_DESC_DEV, DIR_VALUE[2], DIR_INDEX[2], 16'h0000));
    send_item(mk(OP_SETUP, REQ_GET_DESC_DEV, DIR_VALUE[1], DIR_INDEX[1], 16'h0008));
    send_item(mk(OP_SETUP, REQ_GET_DESC_DEV, DIR_VALUE[1], DIR_INDEX[1], 16'h0010));
    send_item(mk(OP_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_SETUP, REQ_GET_DESC_IF, DIR_VALUE[3], DIR_INDEX[3], 16'h0018));
    send_item(mk(OP_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_SETUP, REQ_GET_DESC_DEV, DIR_VALUE[4], LANG_NONE, 16'hFFFF));
    send_item(mk(OP_SETUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(mk(OP_SETUP, REQ_SET_ADDRESS, 16'h0005, 16'h0000, 16'h0000));
    send_item(mk(OP_BUS_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(mk(OP_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(OP_OUT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(mk(OP_SOF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(mk(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  initial begin
    int target;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    target = sent_count;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 66;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 66;
        end
        default: begin
          idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      target += PHASE_ITEMS;
      while (sent_count < target) send_sequence();
    end
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ep0_pkg.sv
sv/ep0_core.sv
sv/ep0_result_fifo.sv
sv/usb_ep0_control_responder.sv
test/usb_ep0_control_responder_tb.sv
